[rtl/core/hmmap_pkg.sv]
// Shared types, constants and the I/O register lookup for the handheld memory map.
// Used by every module of the block except hmmap_ram; it depends on nothing else.
package hmmap_pkg;

    localparam int VRAM_BYTES        = 8192;
    localparam int WRAM_BYTES        = 8192;
    localparam int BANK_BYTES        = 8192;
    localparam int SPRITE_BYTES      = 160;
    localparam int HIGH_RAM_BYTES    = 128;
    localparam int EXT_RAM_BANKS_DEF = 4;
    localparam int IO_COUNT          = 14;
    localparam int IO_W              = $clog2(IO_COUNT);
    localparam int QUEUE_DEPTH       = 2;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_DATA_W         = 40;
    localparam int OUT_DATA_W        = 40;

    // Region boundaries of the bus map.
    localparam logic [15:0] VRAM_BASE     = 16'h8000;
    localparam logic [15:0] EXT_BASE      = 16'hA000;
    localparam logic [15:0] WRAM_BASE     = 16'hC000;
    localparam logic [15:0] OAM_BASE      = 16'hFE00;
    localparam logic [15:0] IO_BASE       = 16'hFF00;
    localparam logic [15:0] HRAM_BASE     = 16'hFF80;
    localparam logic [15:0] IE_ADDR       = 16'hFFFF;
    localparam logic [15:0] BOOT_END      = 16'h0100;
    localparam logic [15:0] BOOT_EXIT_END = 16'h1000;
    localparam logic [15:0] BOOT_EXIT_PC  = 16'h0100;
    localparam logic [7:0]  OAM_LAST      = 8'h9F;
    localparam logic [3:0]  RAM_EN_KEY    = 4'hA;

    localparam logic [1:0] ROM_NONE = 2'd0;
    localparam logic [1:0] ROM_CART = 2'd1;
    localparam logic [1:0] ROM_BOOT = 2'd2;

    // The divider register sits first in the I/O list; any write clears it.
    localparam logic [IO_W-1:0] IO_DIV_IDX = '0;

    localparam logic [15:0] IO_ADDR [IO_COUNT] = '{
        16'hFF04, 16'hFF05, 16'hFF06, 16'hFF07, 16'hFF0F, 16'hFF40, 16'hFF41,
        16'hFF42, 16'hFF43, 16'hFF44, 16'hFF45, 16'hFF47, 16'hFF4A, 16'hFF4B
    };

    typedef enum logic [3:0] {
        REG_LOW,
        REG_VRAM,
        REG_EXT,
        REG_WRAM,
        REG_OAM,
        REG_IE,
        REG_HRAM,
        REG_IO,
        REG_NONE
    } t_region;

    typedef enum logic [1:0] {
        MBC_RAM_EN,
        MBC_ROM_LO,
        MBC_BANK_HI,
        MBC_MODE
    } t_mbc_op;

    typedef enum logic [2:0] {
        SRC_DIRECT,
        SRC_VRAM,
        SRC_EXT,
        SRC_WRAM,
        SRC_OAM,
        SRC_HRAM
    } t_src;

    typedef struct packed {
        logic            kind;
        t_region         region;
        logic [15:0]     addr;
        logic [7:0]      data;
        logic [IO_W-1:0] io_idx;
        t_mbc_op         mbc_op;
        logic            boot_low;
        logic            boot_exit;
    } t_item;

    // Packed so that read_data lands in the lowest bits of the output stream.
    typedef struct packed {
        logic        ram_en;
        logic [6:0]  bank;
        logic [14:0] raddr;
        logic [1:0]  sel;
        logic [7:0]  rdata;
    } t_result;

    typedef struct packed {
        t_src    src;
        t_result res;
    } t_pend;

    typedef struct packed {
        logic            hit;
        logic [IO_W-1:0] idx;
    } t_io_hit;

    function automatic t_io_hit io_lookup(input logic [15:0] addr);
        t_io_hit r;
        r = '0;
        for (int i = 0; i < IO_COUNT; i++) begin
            if (IO_ADDR[i] == addr) begin
                r.hit = 1'b1;
                r.idx = IO_W'(i);
            end
        end
        return r;
    endfunction

endpackage

[rtl/core/handheld_memory_map_mbc1.sv]
// Memory map with MBC1 bank control for an 8-bit handheld bus.
// An accepted transaction passes the queue, the pending stage and the output register.
// Throughput: one transaction per cycle absent back-pressure; one RAM port per access.
// Reset (synchronous, active low) restores bank, boot and I/O state, then a clearing
// pass zeroes all RAM while s_axis_tready is low. Depends on hmmap_pkg, hmmap_front,
// hmmap_queue, hmmap_back and hmmap_ram.
module handheld_memory_map_mbc1 #(
    parameter int EXT_RAM_BANKS = hmmap_pkg::EXT_RAM_BANKS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_wdata,   // mbc1_present
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // address [15:0], write_data [23:16], cpu_pc [39:24]
    input  logic [hmmap_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                                 s_axis_tuser,  // kind: 0 read, 1 write
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // read_data [7:0], rom_select [9:8], rom_address [24:10], rom_bank [31:25],
    // ext_ram_enabled [32], zero fill [39:33]
    output logic [hmmap_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    logic               push, pop, full, empty, busy;
    hmmap_pkg::t_item   front_item, queue_item;
    hmmap_pkg::t_result result;

    hmmap_front u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_full   (full),
        .i_busy   (busy),
        .o_push   (push),
        .o_item   (front_item)
    );

    hmmap_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (queue_item)
    );

    hmmap_back #(.EXT_RAM_BANKS(EXT_RAM_BANKS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_empty     (empty),
        .i_item      (queue_item),
        .o_pop       (pop),
        .o_busy      (busy),
        .i_tready    (m_axis_tready),
        .o_tvalid    (m_axis_tvalid),
        .o_result    (result)
    );

    assign m_axis_tdata = {(hmmap_pkg::OUT_DATA_W - $bits(result))'(0), result};

endmodule

[rtl/core/hmmap_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for every byte store of the memory map.
module hmmap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/hmmap_front.sv]
// Input side: takes bus transactions and classifies them by region and register.
// Depends on hmmap_pkg.
module hmmap_front (
    input  logic                                i_tvalid,
    output logic                                o_tready,
    input  logic [hmmap_pkg::IN_DATA_W-1:0]     i_tdata,
    input  logic                                i_tuser,
    input  logic                                i_full,
    input  logic                                i_busy,
    output logic                                o_push,
    output hmmap_pkg::t_item                    o_item
);

    logic [15:0]         addr;
    logic [7:0]          data;
    logic [15:0]         pc;
    hmmap_pkg::t_io_hit  io_hit;
    hmmap_pkg::t_region  region;
    hmmap_pkg::t_mbc_op  mbc_op;

    assign addr   = i_tdata[15:0];
    assign data   = i_tdata[23:16];
    assign pc     = i_tdata[39:24];
    assign io_hit = hmmap_pkg::io_lookup(addr);

    always_comb begin
        if (addr < hmmap_pkg::VRAM_BASE) begin
            region = hmmap_pkg::REG_LOW;
        end else if (addr < hmmap_pkg::EXT_BASE) begin
            region = hmmap_pkg::REG_VRAM;
        end else if (addr < hmmap_pkg::WRAM_BASE) begin
            region = hmmap_pkg::REG_EXT;
        end else if (addr < hmmap_pkg::OAM_BASE) begin
            region = hmmap_pkg::REG_WRAM;
        end else if (addr < hmmap_pkg::IO_BASE) begin
            // Bytes past the sprite table neither read nor write.
            region = (addr[7:0] <= hmmap_pkg::OAM_LAST) ? hmmap_pkg::REG_OAM
                                                        : hmmap_pkg::REG_NONE;
        end else if (addr == hmmap_pkg::IE_ADDR) begin
            region = hmmap_pkg::REG_IE;
        end else if (addr >= hmmap_pkg::HRAM_BASE) begin
            region = hmmap_pkg::REG_HRAM;
        end else if (io_hit.hit) begin
            region = hmmap_pkg::REG_IO;
        end else begin
            region = hmmap_pkg::REG_NONE;
        end
    end

    always_comb begin
        unique case (addr[14:13])
            2'b00:   mbc_op = hmmap_pkg::MBC_RAM_EN;
            2'b01:   mbc_op = hmmap_pkg::MBC_ROM_LO;
            2'b10:   mbc_op = hmmap_pkg::MBC_BANK_HI;
            default: mbc_op = hmmap_pkg::MBC_MODE;
        endcase
    end

    assign o_tready = !i_full && !i_busy;
    assign o_push   = i_tvalid && o_tready;

    always_comb begin
        o_item           = '0;
        o_item.kind      = i_tuser;
        o_item.region    = region;
        o_item.addr      = addr;
        o_item.data      = data;
        o_item.io_idx    = io_hit.idx;
        o_item.mbc_op    = mbc_op;
        o_item.boot_low  = (addr < hmmap_pkg::BOOT_END);
        o_item.boot_exit = (addr < hmmap_pkg::BOOT_EXIT_END) &&
                           (pc == hmmap_pkg::BOOT_EXIT_PC);
    end

endmodule

[rtl/core/hmmap_queue.sv]
// Short FIFO of classified transactions between the front and back sections.
// Depends on hmmap_pkg.
module hmmap_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hmmap_pkg::t_item i_item,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output hmmap_pkg::t_item o_item
);

    localparam int PW = hmmap_pkg::QPTR_W;
    localparam int CW = hmmap_pkg::QCNT_W;

    hmmap_pkg::t_item r_mem [hmmap_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;

    assign o_full  = (r_count == CW'(hmmap_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(hmmap_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(hmmap_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !(i_push && !i_pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(hmmap_pkg::QUEUE_DEPTH))
        else $error("queue count past its depth");

endmodule

[rtl/core/hmmap_back.sv]
// Execution side: bank registers, boot flag, I/O bytes, the RAM stores and the
// result register. Depends on hmmap_pkg and hmmap_ram.
module hmmap_back #(
    parameter int EXT_RAM_BANKS = hmmap_pkg::EXT_RAM_BANKS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_empty,
    input  hmmap_pkg::t_item   i_item,
    output logic               o_pop,
    output logic               o_busy,
    input  logic               i_tready,
    output logic               o_tvalid,
    output hmmap_pkg::t_result o_result
);

    localparam int EXT_DEPTH = EXT_RAM_BANKS * hmmap_pkg::BANK_BYTES;
    localparam int EXT_AW    = $clog2(EXT_DEPTH);
    localparam int VRAM_AW   = $clog2(hmmap_pkg::VRAM_BYTES);
    localparam int WRAM_AW   = $clog2(hmmap_pkg::WRAM_BYTES);
    localparam int OAM_AW    = $clog2(hmmap_pkg::SPRITE_BYTES);
    localparam int HRAM_AW   = $clog2(hmmap_pkg::HIGH_RAM_BYTES);
    localparam int CLR_W     = EXT_AW;

    // Control and bank state.
    logic              r_mbc1;
    logic              r_boot, n_boot;
    logic [6:0]        r_bank_rom, n_bank_rom;
    logic [1:0]        r_bank_ram, n_bank_ram;
    logic              r_mode, n_mode;
    logic              r_ram_en, n_ram_en;
    logic [7:0]        r_ie, n_ie;
    logic [7:0]        r_io [hmmap_pkg::IO_COUNT];
    logic [7:0]        n_io [hmmap_pkg::IO_COUNT];

    // Clearing sweep after reset.
    logic              r_clr;
    logic [CLR_W-1:0]  r_clr_cnt;

    // Pending stage and output register.
    logic              r_pend_v, n_pend_v;
    hmmap_pkg::t_pend  r_pend, n_pend;
    logic              r_out_v, n_out_v;
    hmmap_pkg::t_result r_out, n_out;
    logic              pend_move;

    hmmap_pkg::t_item  e;
    logic [1:0]        bank_mod;
    logic [14:0]       ext_full;
    logic [4:0]        rom_lo;

    // RAM ports.
    logic               vram_we, wram_we, ext_we, oam_we, hram_we;
    logic               vram_re, wram_re, ext_re, oam_re, hram_re;
    logic [VRAM_AW-1:0] vram_waddr;
    logic [WRAM_AW-1:0] wram_waddr;
    logic [EXT_AW-1:0]  ext_waddr, ext_raddr;
    logic [OAM_AW-1:0]  oam_waddr;
    logic [HRAM_AW-1:0] hram_waddr;
    logic [7:0]         ram_wdata;
    logic [7:0]         vram_q, wram_q, ext_q, oam_q, hram_q;

    assign e         = i_item;
    assign o_busy    = r_clr;
    assign pend_move = r_pend_v && (!r_out_v || i_tready);
    assign o_pop     = !i_empty && !r_clr && (!r_pend_v || pend_move);

    // Bank select reduced to the banks that exist; the value is below four.
    always_comb begin
        if (EXT_RAM_BANKS == 1) begin
            bank_mod = '0;
        end else if (r_bank_ram >= 2'(EXT_RAM_BANKS)) begin
            bank_mod = r_bank_ram - 2'(EXT_RAM_BANKS);
        end else begin
            bank_mod = r_bank_ram;
        end
    end

    assign ext_full  = {bank_mod, e.addr[12:0]};
    assign ext_raddr = ext_full[EXT_AW-1:0];
    assign rom_lo    = (e.data[4:0] == 5'd0) ? 5'd1 : e.data[4:0];

    always_comb begin
        n_boot     = r_boot;
        n_bank_rom = r_bank_rom;
        n_bank_ram = r_bank_ram;
        n_mode     = r_mode;
        n_ram_en   = r_ram_en;
        n_ie       = r_ie;
        n_io       = r_io;
        n_pend     = r_pend;
        vram_we    = 1'b0;
        wram_we    = 1'b0;
        ext_we     = 1'b0;
        oam_we     = 1'b0;
        hram_we    = 1'b0;
        vram_re    = 1'b0;
        wram_re    = 1'b0;
        ext_re     = 1'b0;
        oam_re     = 1'b0;
        hram_re    = 1'b0;
        vram_waddr = e.addr[VRAM_AW-1:0];
        wram_waddr = e.addr[WRAM_AW-1:0];
        ext_waddr  = ext_raddr;
        oam_waddr  = e.addr[OAM_AW-1:0];
        hram_waddr = e.addr[HRAM_AW-1:0];
        ram_wdata  = e.data;

        if (r_clr) begin
            // Every store is zeroed in parallel; the smaller ones wrap or stop early.
            ram_wdata  = '0;
            vram_we    = 1'b1;
            wram_we    = 1'b1;
            ext_we     = 1'b1;
            oam_we     = (r_clr_cnt < CLR_W'(hmmap_pkg::SPRITE_BYTES));
            hram_we    = (r_clr_cnt < CLR_W'(hmmap_pkg::HIGH_RAM_BYTES));
            vram_waddr = r_clr_cnt[VRAM_AW-1:0];
            wram_waddr = r_clr_cnt[WRAM_AW-1:0];
            ext_waddr  = r_clr_cnt[EXT_AW-1:0];
            oam_waddr  = r_clr_cnt[OAM_AW-1:0];
            hram_waddr = r_clr_cnt[HRAM_AW-1:0];
        end

        if (o_pop) begin
            n_pend.src       = hmmap_pkg::SRC_DIRECT;
            n_pend.res.rdata = '0;
            n_pend.res.sel   = hmmap_pkg::ROM_NONE;
            n_pend.res.raddr = '0;
            if (e.kind) begin
                unique case (e.region)
                    hmmap_pkg::REG_LOW: begin
                        if (r_mbc1) begin
                            unique case (e.mbc_op)
                                hmmap_pkg::MBC_RAM_EN: begin
                                    n_ram_en = (e.data[3:0] == hmmap_pkg::RAM_EN_KEY);
                                end
                                hmmap_pkg::MBC_ROM_LO: begin
                                    n_bank_rom = {r_bank_rom[6:5], rom_lo};
                                end
                                hmmap_pkg::MBC_BANK_HI: begin
                                    if (r_mode) begin
                                        n_bank_ram = e.data[1:0];
                                    end else begin
                                        n_bank_rom = {e.data[1:0], r_bank_rom[4:0]};
                                    end
                                end
                                hmmap_pkg::MBC_MODE: begin
                                    n_mode = e.data[0];
                                end
                                default: begin
                                    n_mode = r_mode;
                                end
                            endcase
                        end
                    end
                    hmmap_pkg::REG_VRAM: vram_we = 1'b1;
                    hmmap_pkg::REG_EXT:  ext_we  = 1'b1;
                    hmmap_pkg::REG_WRAM: wram_we = 1'b1;
                    hmmap_pkg::REG_OAM:  oam_we  = 1'b1;
                    hmmap_pkg::REG_IE:   n_ie    = e.data;
                    hmmap_pkg::REG_HRAM: hram_we = 1'b1;
                    hmmap_pkg::REG_IO: begin
                        n_io[e.io_idx] = (e.io_idx == hmmap_pkg::IO_DIV_IDX) ? 8'd0 : e.data;
                    end
                    default: begin
                        n_ie = r_ie;
                    end
                endcase
            end else begin
                unique case (e.region)
                    hmmap_pkg::REG_LOW: begin
                        if (r_boot && e.boot_low) begin
                            n_pend.res.sel = hmmap_pkg::ROM_BOOT;
                        end else begin
                            if (r_boot && e.boot_exit) begin
                                n_boot = 1'b0;
                            end
                            n_pend.res.sel = hmmap_pkg::ROM_CART;
                        end
                        n_pend.res.raddr = e.addr[14:0];
                    end
                    hmmap_pkg::REG_VRAM: begin
                        vram_re    = 1'b1;
                        n_pend.src = hmmap_pkg::SRC_VRAM;
                    end
                    hmmap_pkg::REG_EXT: begin
                        ext_re     = 1'b1;
                        n_pend.src = hmmap_pkg::SRC_EXT;
                    end
                    hmmap_pkg::REG_WRAM: begin
                        wram_re    = 1'b1;
                        n_pend.src = hmmap_pkg::SRC_WRAM;
                    end
                    hmmap_pkg::REG_OAM: begin
                        oam_re     = 1'b1;
                        n_pend.src = hmmap_pkg::SRC_OAM;
                    end
                    hmmap_pkg::REG_IE:   n_pend.res.rdata = r_ie;
                    hmmap_pkg::REG_HRAM: begin
                        hram_re    = 1'b1;
                        n_pend.src = hmmap_pkg::SRC_HRAM;
                    end
                    hmmap_pkg::REG_IO:   n_pend.res.rdata = r_io[e.io_idx];
                    default: begin
                        n_pend.res.rdata = '0;
                    end
                endcase
            end
            n_pend.res.bank   = n_bank_rom;
            n_pend.res.ram_en = n_ram_en;
        end
    end

    always_comb begin
        n_pend_v = r_pend_v;
        if (o_pop) begin
            n_pend_v = 1'b1;
        end else if (pend_move) begin
            n_pend_v = 1'b0;
        end

        n_out_v = r_out_v;
        if (pend_move) begin
            n_out_v = 1'b1;
        end else if (i_tready) begin
            n_out_v = 1'b0;
        end

        n_out = r_pend.res;
        case (r_pend.src)
            hmmap_pkg::SRC_VRAM: n_out.rdata = vram_q;
            hmmap_pkg::SRC_EXT:  n_out.rdata = ext_q;
            hmmap_pkg::SRC_WRAM: n_out.rdata = wram_q;
            hmmap_pkg::SRC_OAM:  n_out.rdata = oam_q;
            hmmap_pkg::SRC_HRAM: n_out.rdata = hram_q;
            default:             n_out.rdata = r_pend.res.rdata;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbc1     <= 1'b0;
            r_boot     <= 1'b1;
            r_bank_rom <= 7'd1;
            r_bank_ram <= '0;
            r_mode     <= 1'b0;
            r_ram_en   <= 1'b0;
            r_ie       <= '0;
            r_io       <= '{default: '0};
            r_clr      <= 1'b1;
            r_clr_cnt  <= '0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mbc1 <= i_cfg_wdata;
            end
            r_boot     <= n_boot;
            r_bank_rom <= n_bank_rom;
            r_bank_ram <= n_bank_ram;
            r_mode     <= n_mode;
            r_ram_en   <= n_ram_en;
            r_ie       <= n_ie;
            r_io       <= n_io;
            if (r_clr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == CLR_W'(EXT_DEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (pend_move) begin
            r_out <= n_out;
        end
    end

    assign o_tvalid = r_out_v;
    assign o_result = r_out;

    hmmap_ram #(.WIDTH(8), .DEPTH(hmmap_pkg::VRAM_BYTES)) u_vram (
        .i_clk   (i_clk),
        .i_we    (vram_we),
        .i_waddr (vram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (vram_re),
        .i_raddr (e.addr[VRAM_AW-1:0]),
        .o_rdata (vram_q)
    );

    hmmap_ram #(.WIDTH(8), .DEPTH(hmmap_pkg::WRAM_BYTES)) u_wram (
        .i_clk   (i_clk),
        .i_we    (wram_we),
        .i_waddr (wram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (wram_re),
        .i_raddr (e.addr[WRAM_AW-1:0]),
        .o_rdata (wram_q)
    );

    hmmap_ram #(.WIDTH(8), .DEPTH(EXT_DEPTH)) u_ext_ram (
        .i_clk   (i_clk),
        .i_we    (ext_we),
        .i_waddr (ext_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ext_re),
        .i_raddr (ext_raddr),
        .o_rdata (ext_q)
    );

    hmmap_ram #(.WIDTH(8), .DEPTH(hmmap_pkg::SPRITE_BYTES)) u_oam (
        .i_clk   (i_clk),
        .i_we    (oam_we),
        .i_waddr (oam_waddr),
        .i_wdata (ram_wdata),
        .i_re    (oam_re),
        .i_raddr (e.addr[OAM_AW-1:0]),
        .o_rdata (oam_q)
    );

    hmmap_ram #(.WIDTH(8), .DEPTH(hmmap_pkg::HIGH_RAM_BYTES)) u_hram (
        .i_clk   (i_clk),
        .i_we    (hram_we),
        .i_waddr (hram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (hram_re),
        .i_raddr (e.addr[HRAM_AW-1:0]),
        .o_rdata (hram_q)
    );

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !o_pop)
        else $error("transaction executed during the clearing sweep");

    a_rom_bank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bank_rom[4:0] != 5'd0)
        else $error("low ROM bank bits reached zero");

    a_boot_stays_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_boot |=> !r_boot)
        else $error("boot mapping came back without a reset");

    a_boot_fetch_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.sel == hmmap_pkg::ROM_BOOT) |-> (r_out.raddr[14:8] == 7'd0))
        else $error("boot ROM fetch outside the boot window");

    a_pend_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_v && !pend_move) |=> (r_pend_v && $stable(r_pend)))
        else $error("pending result changed while stalled");

endmodule

[tb/handheld_memory_map_mbc1_test.sv]
// Self-checking testbench for the MBC1 handheld memory map: directed table, then random bus traffic.
// Uses its own predictor of the bus map and bank registers; depends only on hmmap_pkg and the top level.
module handheld_memory_map_mbc1_test;

    localparam int CLK_PERIOD     = 12;
    localparam int LIMIT_CYCLES   = 600000;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int RX_HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS    = 170;
    localparam int PRINT_LIMIT    = 40;

    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;

    localparam logic [15:0] VRAM_START   = 16'h8000;
    localparam logic [15:0] EXT_START    = 16'hA000;
    localparam logic [15:0] WRAM_START   = 16'hC000;
    localparam logic [15:0] OAM_START    = 16'hFE00;
    localparam logic [15:0] IO_START     = 16'hFF00;
    localparam logic [15:0] HRAM_START   = 16'hFF80;
    localparam logic [15:0] IE_ADDRESS   = 16'hFFFF;
    localparam logic [15:0] BOOT_LIMIT   = 16'h0100;
    localparam logic [15:0] BOOT_LEAVE   = 16'h1000;
    localparam logic [15:0] BOOT_EXIT_PC = 16'h0100;
    localparam logic [7:0]  OAM_TOP      = 8'h9F;
    localparam logic [3:0]  RAM_EN_NIBBLE = 4'hA;
    localparam int          DIV_SLOT     = 0;

    localparam logic [15:0] IO_MAP [14] = '{
        16'hFF04, 16'hFF05, 16'hFF06, 16'hFF07, 16'hFF0F, 16'hFF40, 16'hFF41,
        16'hFF42, 16'hFF43, 16'hFF44, 16'hFF45, 16'hFF47, 16'hFF4A, 16'hFF4B
    };

    // Same bit order as m_axis_tdata[32:0], so a result can be taken straight off the bus.
    typedef struct packed {
        logic        ext_ram_enabled;
        logic [6:0]  rom_bank;
        logic [14:0] rom_address;
        logic [1:0]  rom_select;
        logic [7:0]  read_data;
    } mm_result_t;

    typedef enum bit {ROW_ACCESS, ROW_CONFIG} row_kind_t;

    typedef struct packed {
        row_kind_t   what;
        logic        is_write;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [15:0] pc;
        bit          typed;
        mm_result_t  want;
    } bus_row_t;

    // want columns: ext_ram_enabled, rom_bank, rom_address, rom_select, read_data
    localparam bus_row_t DIRECTED_ROWS [26] = '{
        '{ROW_ACCESS, ACC_READ,  16'h0000, 8'h00, 16'h0000, 1'b1,
          '{1'b0, 7'h01, 15'h0000, hmmap_pkg::ROM_BOOT, 8'h00}},
        '{ROW_ACCESS, ACC_READ,  16'h00FF, 8'hFF, 16'hFFFF, 1'b1,
          '{1'b0, 7'h01, 15'h00FF, hmmap_pkg::ROM_BOOT, 8'h00}},
        '{ROW_ACCESS, ACC_READ,  16'h0FFF, 8'h00, 16'h0101, 1'b0, '0},
        '{ROW_ACCESS, ACC_READ,  16'h7FFF, 8'h00, 16'h0100, 1'b1,
          '{1'b0, 7'h01, 15'h7FFF, hmmap_pkg::ROM_CART, 8'h00}},
        '{ROW_ACCESS, ACC_WRITE, 16'h0000, 8'h0A, 16'h0000, 1'b1,
          '{1'b0, 7'h01, 15'h0000, hmmap_pkg::ROM_NONE, 8'h00}},
        '{ROW_ACCESS, ACC_WRITE, 16'hE000, 8'h81, 16'h0000, 1'b0, '0},
        '{ROW_ACCESS, ACC_READ,  16'hC000, 8'h00, 16'h0000, 1'b0, '0},
        '{ROW_ACCESS, ACC_WRITE, 16'hFEA0, 8'h33, 16'h0000, 1'b0, '0},
        '{ROW_ACCESS, ACC_READ,  16'hFEA0, 8'h00, 16'h0000, 1'b1,
          '{1'b0, 7'h01, 15'h0000, hmmap_pkg::ROM_NONE, 8'h00}},
        '{ROW_ACCESS, ACC_WRITE, 16'hFE9F, 8'hC3, 16'h0000, 1'b0, '0},
        '{ROW_ACCESS, ACC_READ,  16'hFE9F, 8'h00, 16'h0000, 1'b0, '0},
        '{ROW_ACCESS, ACC_WRITE, 16'hFF04, 8'h5A, 16'h0000, 1'b0, '0},
        '{ROW_ACCESS, ACC_READ,  16'hFF04, 8'h00, 16'h0000, 1'b1,
          '{1'b0, 7'h01, 15'h0000, hmmap_pkg::ROM_NONE, 8'h00}},
        '{ROW_ACCESS, ACC_WRITE, 16'hFF46, 8'h77, 16'h0000, 1'b0, '0},
        '{ROW_ACCESS, ACC_READ,  16'hFF46, 8'h00, 16'h0000, 1'b1,
          '{1'b0, 7'h01, 15'h0000, hmmap_pkg::ROM_NONE, 8'h00}},
        '{ROW_ACCESS, ACC_WRITE, 16'hFFFF, 8'hFF, 16'h0000, 1'b0, '0},
        '{ROW_ACCESS, ACC_READ,  16'hFFFF, 8'h00, 16'h0000, 1'b0, '0},
        '{ROW_CONFIG, ACC_WRITE, 16'h0000, 8'h01, 16'h0000, 1'b0, '0},
        '{ROW_ACCESS, ACC_WRITE, 16'h1FFF, 8'h3A, 16'h0000, 1'b0, '0},
        '{ROW_ACCESS, ACC_WRITE, 16'h2000, 8'h00, 16'h0000, 1'b0, '0},
        '{ROW_ACCESS, ACC_WRITE, 16'h3FFF, 8'hFF, 16'h0000, 1'b0, '0},
        '{ROW_ACCESS, ACC_WRITE, 16'h5FFF, 8'h03, 16'h0000, 1'b0, '0},
        '{ROW_ACCESS, ACC_WRITE, 16'h7FFF, 8'h01, 16'h0000, 1'b0, '0},
        '{ROW_ACCESS, ACC_WRITE, 16'h4000, 8'h02, 16'h0000, 1'b0, '0},
        '{ROW_ACCESS, ACC_READ,  16'h0100, 8'h00, 16'h0100, 1'b0, '0},
        '{ROW_ACCESS, ACC_READ,  16'h0000, 8'h00, 16'h0000, 1'b0, '0}
    };

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic                             i_cfg_wdata;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [hmmap_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // address, write_data, cpu_pc
    logic                             s_axis_tuser;   // kind
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    // read_data, rom_select, rom_address, rom_bank, ext_ram_enabled, zero fill
    logic [hmmap_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    handheld_memory_map_mbc1 u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predictor copy of the bus map state.
    bit          mbc1_on;
    bit          boot_on;
    bit [7:0]    vram    [8192];
    bit [7:0]    wram    [8192];
    bit [7:0]    ext_ram [32768];
    bit [7:0]    oam     [160];
    bit [7:0]    hram    [128];
    bit [7:0]    io_q    [14];
    bit [7:0]    ie_q;
    bit [6:0]    rom_bank_q;
    bit [1:0]    ram_bank_q;
    bit          bank_mode_q;
    bit          ram_en_q;

    mm_result_t  expected_bus_results [$];
    int          mismatch_count;
    int          reads_sent;
    int          writes_sent;
    int          results_checked;
    int          rom_fetches;
    int          tx_calm_left;
    int          tx_burst_left;
    bit          rx_hold_req;
    mm_result_t  bus_got;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int io_slot(input logic [15:0] addr);
        int slot;
        slot = -1;
        for (int i = 0; i < 14; i++)
            if (IO_MAP[i] == addr) slot = i;
        return slot;
    endfunction

    function automatic mm_result_t predict_access(input logic kind, input logic [15:0] addr,
                                                  input logic [7:0] wdata,
                                                  input logic [15:0] pc);
        mm_result_t r;
        int         slot;
        logic [4:0] low_bank;
        r = '0;
        if (kind == ACC_WRITE) begin
            if (addr < VRAM_START) begin
                if (mbc1_on) begin
                    if (addr < 16'h2000) begin
                        ram_en_q = (wdata[3:0] == RAM_EN_NIBBLE);
                    end else if (addr < 16'h4000) begin
                        // Bank zero in the low field always selects bank one.
                        low_bank = (wdata[4:0] == 5'd0) ? 5'd1 : wdata[4:0];
                        rom_bank_q[4:0] = low_bank;
                    end else if (addr < 16'h6000) begin
                        if (bank_mode_q) ram_bank_q = wdata[1:0];
                        else rom_bank_q[6:5] = wdata[1:0];
                    end else begin
                        bank_mode_q = wdata[0];
                    end
                end
            end else if (addr < EXT_START) begin
                vram[addr[12:0]] = wdata;
            end else if (addr < WRAM_START) begin
                ext_ram[{ram_bank_q, addr[12:0]}] = wdata;
            end else if (addr < OAM_START) begin
                wram[addr[12:0]] = wdata;
            end else if (addr < IO_START) begin
                if (addr[7:0] <= OAM_TOP) oam[addr[7:0]] = wdata;
            end else if (addr == IE_ADDRESS) begin
                ie_q = wdata;
            end else if (addr >= HRAM_START) begin
                hram[addr[6:0]] = wdata;
            end else begin
                slot = io_slot(addr);
                if (slot == DIV_SLOT) io_q[slot] = 8'h00;
                else if (slot > 0) io_q[slot] = wdata;
            end
        end else if (addr < VRAM_START) begin
            if (boot_on && addr < BOOT_LIMIT) begin
                r.rom_select = hmmap_pkg::ROM_BOOT;
            end else begin
                if (boot_on && addr < BOOT_LEAVE && pc == BOOT_EXIT_PC) boot_on = 1'b0;
                r.rom_select = hmmap_pkg::ROM_CART;
            end
            r.rom_address = addr[14:0];
        end else begin
            if (addr < EXT_START) begin
                r.read_data = vram[addr[12:0]];
            end else if (addr < WRAM_START) begin
                r.read_data = ext_ram[{ram_bank_q, addr[12:0]}];
            end else if (addr < OAM_START) begin
                r.read_data = wram[addr[12:0]];
            end else if (addr < IO_START) begin
                r.read_data = (addr[7:0] <= OAM_TOP) ? oam[addr[7:0]] : 8'h00;
            end else if (addr == IE_ADDRESS) begin
                r.read_data = ie_q;
            end else if (addr >= HRAM_START) begin
                r.read_data = hram[addr[6:0]];
            end else begin
                slot = io_slot(addr);
                if (slot >= 0) r.read_data = io_q[slot];
            end
        end
        r.rom_bank        = rom_bank_q;
        r.ext_ram_enabled = ram_en_q;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input longint unsigned want_v,
                                 input longint unsigned got_v);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH %s: expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
        mismatch_count++;
    endtask

    task automatic check_result(input mm_result_t want, input mm_result_t got);
        if (got.read_data != want.read_data)
            note_mismatch("read_data", want.read_data, got.read_data);
        if (got.rom_select != want.rom_select)
            note_mismatch("rom_select", want.rom_select, got.rom_select);
        if (got.rom_address != want.rom_address)
            note_mismatch("rom_address", want.rom_address, got.rom_address);
        if (got.rom_bank != want.rom_bank)
            note_mismatch("rom_bank", want.rom_bank, got.rom_bank);
        if (got.ext_ram_enabled != want.ext_ram_enabled)
            note_mismatch("ext_ram_enabled", want.ext_ram_enabled, got.ext_ram_enabled);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            bus_got = m_axis_tdata[32:0];
            if (expected_bus_results.size() == 0) begin
                note_mismatch("result with nothing expected", 0, bus_got);
            end else begin
                check_result(expected_bus_results.pop_front(), bus_got);
                results_checked++;
                if (bus_got.rom_select != hmmap_pkg::ROM_NONE) rom_fetches++;
            end
        end
    end

    // Receiver: random back-pressure, calm stretches, and one long hold on request.
    initial begin
        int low_left;
        int calm_left;
        int roll;
        low_left  = 0;
        calm_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (low_left > 0) begin
                low_left--;
                m_axis_tready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                m_axis_tready <= 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 5) calm_left = $urandom_range(10, 50);
                else if (roll < 20) low_left = $urandom_range(0, 2);
                else if (roll < 23) low_left = $urandom_range(8, 30);
                m_axis_tready <= (roll >= 5 && roll < 23) ? 1'b0 : 1'b1;
            end
        end
    end

    function automatic int tx_gap();
        int roll;
        if (tx_burst_left > 0) begin
            tx_burst_left--;
            return 0;
        end
        if (tx_calm_left > 0) begin
            tx_calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            tx_calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic offer_access(input logic kind, input logic [15:0] addr,
                                input logic [7:0] data, input logic [15:0] pc,
                                input bit typed, input mm_result_t want);
        int         gap;
        mm_result_t predicted;
        gap = tx_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {pc, data, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = predict_access(kind, addr, data, pc);
        expected_bus_results.push_back(typed ? want : predicted);
        if (kind == ACC_WRITE) writes_sent++;
        else reads_sent++;
    endtask

    // Holds the sender off until every expected result has come back.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_bus_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mbc1_on = value;
    endtask

    task automatic roll_access(output logic kind, output logic [15:0] addr,
                               output logic [7:0] data, output logic [15:0] pc);
        int pick;
        int off;
        pick = $urandom_range(0, 99);
        kind = 1'($urandom_range(0, 1));
        data = 8'($urandom);
        pc   = ($urandom_range(0, 7) == 0) ? BOOT_EXIT_PC : 16'($urandom);
        // Small offsets make reads land on bytes written earlier.
        off  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 8191);
        if (pick < 12) begin
            addr = 16'($urandom_range(0, 16'h7FFF));
        end else if (pick < 24) begin
            kind = ACC_WRITE;
            addr = 16'($urandom_range(0, 3) * 16'h2000 + off);
            if ($urandom_range(0, 1) == 0) data[3:0] = RAM_EN_NIBBLE;
        end else if (pick < 36) begin
            addr = VRAM_START + 16'(off);
        end else if (pick < 50) begin
            addr = EXT_START + 16'(off);
        end else if (pick < 62) begin
            if ($urandom_range(0, 1) == 0)
                addr = WRAM_START + 16'($urandom_range(0, 15))
                     + (($urandom_range(0, 1) == 0) ? 16'h0000 : 16'h2000);
            else
                addr = WRAM_START + 16'($urandom_range(0, 16'h3DFF));
        end else if (pick < 70) begin
            addr = OAM_START + 16'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                                : $urandom_range(0, 255));
        end else if (pick < 82) begin
            addr = ($urandom_range(0, 1) == 0) ? IO_MAP[$urandom_range(0, 13)]
                                                : IO_START + 16'($urandom_range(0, 127));
        end else if (pick < 92) begin
            addr = HRAM_START + 16'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 7)
                                                                 : $urandom_range(0, 126));
        end else if (pick < 97) begin
            addr = IE_ADDRESS;
        end else begin
            addr = 16'($urandom);
        end
    endtask

    initial begin
        logic        kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [15:0] pc;
        int          waited;

        mismatch_count  = 0;
        reads_sent      = 0;
        writes_sent     = 0;
        results_checked = 0;
        rom_fetches     = 0;
        tx_calm_left    = 0;
        tx_burst_left   = 0;
        rx_hold_req     = 1'b0;
        mbc1_on         = 1'b0;
        boot_on         = 1'b1;
        ie_q            = 8'h00;
        rom_bank_q      = 7'h01;
        ram_bank_q      = 2'd0;
        bank_mode_q     = 1'b0;
        ram_en_q        = 1'b0;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= ACC_READ;
        s_axis_tdata  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_config(1'b0);

        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].what == ROW_CONFIG) begin
                wait_idle();
                write_config(DIRECTED_ROWS[i].data[0]);
            end else begin
                offer_access(DIRECTED_ROWS[i].is_write, DIRECTED_ROWS[i].addr,
                             DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].pc,
                             DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
            end
        end

        // Random traffic with MBC1 alternately on and off.
        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            write_config((phase % 2) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 1 && n == 60) begin
                    // Back-to-back transactions against a stalled receiver fill the block.
                    rx_hold_req   = 1'b1;
                    tx_burst_left = 30;
                end
                if (phase == 2 && n == 90) wait_idle();
                roll_access(kind, addr, data, pc);
                offer_access(kind, addr, data, pc, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (expected_bus_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_bus_results.size() != 0)
            note_mismatch("results never delivered", 0, expected_bus_results.size());

        $display("Sent %0d reads and %0d writes over every region, MBC1 on and off.",
                 reads_sent, writes_sent);
        $display("Checked %0d results, %0d of them ROM fetch requests; %0d mismatches.",
                 results_checked, rom_fetches, mismatch_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/hmmap_pkg.sv
rtl/core/hmmap_ram.sv
rtl/core/hmmap_front.sv
rtl/core/hmmap_queue.sv
rtl/core/hmmap_back.sv
rtl/core/handheld_memory_map_mbc1.sv
tb/handheld_memory_map_mbc1_test.sv
